/* rtl/pmct_pkg.sv */
`timescale 1ns / 1ps

package pmct_pkg;

  typedef enum logic [1:0] {
    REG_SENSITIVITY = 2'd0,
    REG_SCREEN_COLS = 2'd1,
    REG_SCREEN_ROWS = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLAMP = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  localparam int unsigned HDR_SYNC_BIT = 3;
  localparam int unsigned FINE_W       = 16;
  localparam int unsigned SUM_W        = FINE_W + 2;
  localparam int unsigned DIV_W        = 9;

  localparam logic [7:0]        SENS_RST   = 8'd6;
  localparam logic [7:0]        COLS_RST   = 8'd80;
  localparam logic [6:0]        ROWS_RST   = 7'd25;
  localparam logic [FINE_W-1:0] FINE_X_RST = 16'd474;
  localparam logic [6:0]        POS_MAX    = 7'd127;

endpackage

/* rtl/ps2_mouse_packet_cursor_tracker_core.sv */
`timescale 1ns / 1ps

// PS/2 mouse packet decoder with text-cursor tracking. Mouse bytes come in on
// the input channel; a header byte starts a packet only when its bit 3 is
// set, then the X and Y delta bytes follow. The Y byte of a packet yields one
// request on the output channel with the cursor column and row and the three
// button states. The Y byte is worked in steps: add the deltas and form the
// clamp bounds, clamp, run the bit-serial restoring dividers that produce
// column and row (one quotient bit per cycle, both in parallel), and load the
// output register. While a request is still pending at the output, a further
// Y byte is held off. Configuration writes take effect at the next Y byte.
module ps2_mouse_packet_cursor_tracker_core
  import pmct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] cursor_col_o,
  output logic [6:0] cursor_row_o,
  output logic       left_down_o,
  output logic       right_down_o,
  output logic       middle_down_o
);

  logic [7:0] sens_q, cols_q;
  logic [6:0] rows_q;

  phase_e phase_q;
  state_e state_q;
  logic [7:0] header_q, xdelta_q;
  logic [FINE_W-1:0] fine_x_q, fine_y_q;

  logic [SUM_W-1:0]  xsum_q, ysum_q;
  logic [FINE_W-1:0] hx_q, hy_q;
  logic [DIV_W-1:0]  dx_q, dy_q;
  logic [FINE_W-1:0] qx_q, qy_q;
  logic [DIV_W-1:0]  rx_q, ry_q;
  logic [3:0]        cnt_q;

  logic       out_valid_q;
  logic [6:0] col_q, row_q;
  logic [2:0] btn_q;

  logic in_acc;
  logic [7:0] sens_eff, cols_m1;
  logic [DIV_W-1:0] sens_p1;
  logic [FINE_W-1:0] hx_d, hy_d;
  logic [SUM_W-1:0] xsum_d, ysum_d;
  logic [FINE_W-1:0] xcl, ycl;
  logic [DIV_W:0] rxs, rys, rx_sub, ry_sub;
  logic gex, gey;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && phase_q == PH_Y);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    sens_eff = (sens_q == 8'd0) ? 8'd1 : sens_q;
    cols_m1  = (cols_q == 8'd0) ? 8'd0 : cols_q - 8'd1;
    sens_p1  = {1'b0, sens_eff} + 9'd1;
    hx_d     = {8'd0, cols_m1} * {8'd0, sens_eff};
    hy_d     = {9'd0, rows_q} * {7'd0, sens_p1};
    xsum_d   = {2'b00, fine_x_q} + {{(SUM_W-8){xdelta_q[7]}}, xdelta_q};
    ysum_d   = {2'b00, fine_y_q} - {{(SUM_W-8){data_byte_i[7]}}, data_byte_i};
  end

  always_comb begin
    if (xsum_q[SUM_W-1]) begin
      xcl = '0;
    end else if (xsum_q[SUM_W-2:0] > {1'b0, hx_q}) begin
      xcl = hx_q;
    end else begin
      xcl = xsum_q[FINE_W-1:0];
    end
    if (ysum_q[SUM_W-1]) begin
      ycl = '0;
    end else if (ysum_q[SUM_W-2:0] > {1'b0, hy_q}) begin
      ycl = hy_q;
    end else begin
      ycl = ysum_q[FINE_W-1:0];
    end
  end

  always_comb begin
    rxs    = {rx_q, qx_q[FINE_W-1]};
    rys    = {ry_q, qy_q[FINE_W-1]};
    gex    = rxs >= {1'b0, dx_q};
    gey    = rys >= {1'b0, dy_q};
    rx_sub = gex ? rxs - {1'b0, dx_q} : rxs;
    ry_sub = gey ? rys - {1'b0, dy_q} : rys;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= SENS_RST;
      cols_q <= COLS_RST;
      rows_q <= ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SENSITIVITY: sens_q <= cfg_wdata_i;
        REG_SCREEN_COLS: cols_q <= cfg_wdata_i;
        REG_SCREEN_ROWS: rows_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      state_q     <= ST_IDLE;
      header_q    <= '0;
      xdelta_q    <= '0;
      fine_x_q    <= FINE_X_RST;
      fine_y_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (phase_q)
              PH_HEADER: begin
                header_q <= data_byte_i;
                if (data_byte_i[HDR_SYNC_BIT]) begin
                  phase_q <= PH_X;
                end
              end
              PH_X: begin
                xdelta_q <= data_byte_i;
                phase_q  <= PH_Y;
              end
              PH_Y: begin
                phase_q <= PH_HEADER;
                state_q <= ST_CLAMP;
              end
              default: phase_q <= PH_HEADER;
            endcase
          end
        end
        ST_CLAMP: begin
          fine_x_q <= xcl;
          fine_y_q <= ycl;
          cnt_q    <= 4'd15;
          state_q  <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == 4'd0) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && phase_q == PH_Y) begin
      xsum_q <= xsum_d;
      ysum_q <= ysum_d;
      hx_q   <= hx_d;
      hy_q   <= hy_d;
      dx_q   <= {1'b0, sens_eff};
      dy_q   <= sens_p1;
    end
    if (state_q == ST_CLAMP) begin
      qx_q <= xcl;
      qy_q <= ycl;
      rx_q <= '0;
      ry_q <= '0;
    end else if (state_q == ST_DIV) begin
      qx_q <= {qx_q[FINE_W-2:0], gex};
      qy_q <= {qy_q[FINE_W-2:0], gey};
      rx_q <= rx_sub[DIV_W-1:0];
      ry_q <= ry_sub[DIV_W-1:0];
    end
    if (state_q == ST_DONE) begin
      col_q <= (|qx_q[FINE_W-1:7]) ? POS_MAX : qx_q[6:0];
      row_q <= (|qy_q[FINE_W-1:7]) ? POS_MAX : qy_q[6:0];
      btn_q <= header_q[2:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_col_o  = col_q;
  assign cursor_row_o  = row_q;
  assign left_down_o   = btn_q[0];
  assign right_down_o  = btn_q[1];
  assign middle_down_o = btn_q[2];

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall_o)
    else $error("input taken while a packet is in progress");

  a_done_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> !out_valid_q)
    else $error("result would overwrite a pending request");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == 4'd0) |=> state_q == ST_DONE)
    else $error("divider did not finish after 16 steps");

  a_fine_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fine_y_q[FINE_W-1])
    else $error("fine Y position out of range");

endmodule

/* verif/ps2_mouse_packet_cursor_tracker_core_tb.sv */
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_core_tb
  import pmct_pkg::*;
();

  typedef struct packed {
    logic [6:0] col;
    logic [6:0] row;
    logic       left;
    logic       right;
    logic       middle;
  } cursor_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    cursor_t    res;
  } dir_row_t;

  localparam int      WDOG_LIMIT = 3000;
  localparam int      HOLD_LEN   = 300;
  localparam int      PHASE_ITEMS = 150;
  localparam int      N_PHASES   = 9;
  localparam cursor_t NO_RES     = '0;

  logic       clk_i     = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_idx   = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic [7:0] data_byte = '0;
  logic       rx_stall  = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic [6:0] got_col;
  logic [6:0] got_row;
  logic       got_left;
  logic       got_right;
  logic       got_middle;
  cursor_t    got;

  ps2_mouse_packet_cursor_tracker_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (rx_stall),
    .cursor_col_o (got_col),
    .cursor_row_o (got_row),
    .left_down_o  (got_left),
    .right_down_o (got_right),
    .middle_down_o(got_middle)
  );

  assign got = {got_col, got_row, got_left, got_right, got_middle};

  always #10 clk_i = ~clk_i;

  // tracker state mirrored from the decoder
  phase_e      trk_phase = PH_HEADER;
  logic [7:0]  trk_hdr   = '0;
  logic [7:0]  trk_dx    = '0;
  logic [15:0] trk_fx    = FINE_X_RST;
  logic [15:0] trk_fy    = '0;
  logic [7:0]  cfg_sens  = SENS_RST;
  logic [7:0]  cfg_cols  = COLS_RST;
  logic [6:0]  cfg_rows  = ROWS_RST;

  cursor_t exp_cursor_q [$];
  int      bytes_used   = 0;
  int      err_cnt      = 0;
  int      stuck_cnt    = 0;
  int      snd_idle_pct = 17;
  int      rcv_idle_pct = 69;
  int      hold_seq     = 0;
  int      hold_seen    = 0;
  int      hold_left    = 0;

  dir_row_t dir_rows [23];

  function automatic bit track_packet_byte(input logic [7:0] b, output cursor_t r);
    int s, c, x, y, col, row;
    r = '0;
    if (trk_phase != PH_HEADER || b[HDR_SYNC_BIT]) bytes_used++;
    case (trk_phase)
      PH_HEADER: begin
        trk_hdr = b;
        if (b[HDR_SYNC_BIT]) trk_phase = PH_X;
        return 1'b0;
      end
      PH_X: begin
        trk_dx    = b;
        trk_phase = PH_Y;
        return 1'b0;
      end
      PH_Y: ;
      default: begin
        trk_phase = PH_HEADER;
        return 1'b0;
      end
    endcase
    trk_phase = PH_HEADER;
    s = (cfg_sens != 0) ? int'(cfg_sens) : 1;
    c = (cfg_cols != 0) ? int'(cfg_cols) : 1;
    x = int'(trk_fx) + int'($signed(trk_dx));
    y = int'(trk_fy) - int'($signed(b));
    if (x > (c - 1) * s) x = (c - 1) * s;
    if (x < 0) x = 0;
    if (y > int'(cfg_rows) * (s + 1)) y = int'(cfg_rows) * (s + 1);
    if (y < 0) y = 0;
    trk_fx = x[15:0];
    trk_fy = y[15:0];
    col = x / s;
    row = y / (s + 1);
    if (col > int'(POS_MAX)) col = int'(POS_MAX);
    if (row > int'(POS_MAX)) row = int'(POS_MAX);
    r.col    = col[6:0];
    r.row    = row[6:0];
    r.left   = trk_hdr[0];
    r.right  = trk_hdr[1];
    r.middle = trk_hdr[2];
    return 1'b1;
  endfunction

  task automatic feed_byte(input logic [7:0] b, input bit typed, input cursor_t typed_res);
    cursor_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk_i); while (in_stall);
    if (track_packet_byte(b, r)) exp_cursor_q.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_SENSITIVITY: cfg_sens = val;
      REG_SCREEN_COLS: cfg_cols = val;
      REG_SCREEN_ROWS: cfg_rows = val[6:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (exp_cursor_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_delta();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'h7F : 8'h80;
    return 8'($urandom_range(255));
  endfunction

  always @(negedge clk_i) begin : rx_side
    logic st;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      st = 1'b1;
    end else begin
      st = ($urandom_range(99) < rcv_idle_pct);
    end
    rx_stall <= st;
  end

  always @(posedge clk_i) begin : monitor
    cursor_t e;
    if (rst_n) begin
      if (out_valid && !rx_stall) begin
        if (exp_cursor_q.size() == 0) begin
          $error("unexpected result: col %0d row %0d", got.col, got.row);
          err_cnt++;
        end else begin
          e = exp_cursor_q.pop_front();
          if (got.col !== e.col) begin
            $error("cursor_col: expected %0d, got %0d", e.col, got.col);
            err_cnt++;
          end
          if (got.row !== e.row) begin
            $error("cursor_row: expected %0d, got %0d", e.row, got.row);
            err_cnt++;
          end
          if (got.left !== e.left) begin
            $error("left_down: expected %0d, got %0d", e.left, got.left);
            err_cnt++;
          end
          if (got.right !== e.right) begin
            $error("right_down: expected %0d, got %0d", e.right, got.right);
            err_cnt++;
          end
          if (got.middle !== e.middle) begin
            $error("middle_down: expected %0d, got %0d", e.middle, got.middle);
            err_cnt++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !rx_stall)) stuck_cnt = 0;
      else stuck_cnt++;
    end
  end

  initial begin : watchdog
    wait (stuck_cnt >= WDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] sens_set [4];
    logic [7:0] cols_set [4];
    logic [6:0] rows_set [4];
    int target;

    // zero and oversize settings, then low and high bounds
    sens_set = '{8'd0, 8'd255, 8'd1, 8'd255};
    cols_set = '{8'd0, 8'd200, 8'd2, 8'd128};
    rows_set = '{7'd0, 7'd127, 7'd1, 7'd64};

    dir_rows = '{
      '{8'h00, 1'b0, NO_RES},
      '{8'hF7, 1'b0, NO_RES},
      '{8'h08, 1'b0, NO_RES},
      '{8'h00, 1'b0, NO_RES},
      '{8'h00, 1'b1, '{7'd79, 7'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h0F, 1'b0, NO_RES},
      '{8'h7F, 1'b0, NO_RES},
      '{8'h80, 1'b1, '{7'd79, 7'd18, 1'b1, 1'b1, 1'b1}},
      '{8'hFF, 1'b0, NO_RES},
      '{8'h80, 1'b0, NO_RES},
      '{8'h7F, 1'b0, NO_RES},
      '{8'h09, 1'b0, NO_RES},
      '{8'h80, 1'b0, NO_RES},
      '{8'h80, 1'b0, NO_RES},
      '{8'h0A, 1'b0, NO_RES},
      '{8'h80, 1'b0, NO_RES},
      '{8'h80, 1'b1, '{7'd15, 7'd25, 1'b0, 1'b1, 1'b0}},
      '{8'h0C, 1'b0, NO_RES},
      '{8'h80, 1'b0, NO_RES},
      '{8'h7F, 1'b0, NO_RES},
      '{8'h08, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{8'h7F, 1'b1, '{7'd0, 7'd0, 1'b0, 1'b0, 1'b0}}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) feed_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p / 3)
        0: begin
          snd_idle_pct = 17;
          rcv_idle_pct = 69;
        end
        1: begin
          snd_idle_pct = 69;
          rcv_idle_pct = 17;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      wait_idle();
      if (p < 4) begin
        write_reg(REG_SENSITIVITY, sens_set[p]);
        write_reg(REG_SCREEN_COLS, cols_set[p]);
        write_reg(REG_SCREEN_ROWS, {1'b0, rows_set[p]});
      end else begin
        write_reg(REG_SCREEN_ROWS, 8'($urandom_range(64, 1)));
        write_reg(REG_SCREEN_COLS, 8'($urandom_range(128, 2)));
        write_reg(REG_SENSITIVITY, 8'($urandom_range(255, 1)));
      end
      // output held off while bytes keep coming
      if (p == 6) hold_seq++;
      target = bytes_used + PHASE_ITEMS;
      while (bytes_used < target) begin
        if ($urandom_range(99) < 85) begin
          feed_byte(8'($urandom_range(255)) | 8'h08, 1'b0, NO_RES);
          feed_byte(rand_delta(), 1'b0, NO_RES);
          feed_byte(rand_delta(), 1'b0, NO_RES);
        end else begin
          feed_byte(8'($urandom_range(255)), 1'b0, NO_RES);
        end
      end
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && exp_cursor_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
